// ===== hw/rtl/amu_pkg.sv =====
package amu_pkg;

    localparam int ENTRIES_DEF    = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // fixed widths of the word fields
    localparam int OP_W     = 4;
    localparam int FORM_W   = 2;
    localparam int ADDR_W   = 6;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_SET   = 4'd0,
        OP_ADD   = 4'd1,
        OP_SUB   = 4'd2,
        OP_MUL   = 4'd3,
        OP_DIV   = 4'd4,
        OP_INC   = 4'd5,
        OP_DEC   = 4'd6,
        OP_MOVE  = 4'd7,
        OP_LOAD  = 4'd8,
        OP_STORE = 4'd9,
        OP_SHOW  = 4'd10
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_DIV0 = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        FN_ADD = 2'd0,
        FN_SUB = 2'd1,
        FN_MUL = 2'd2,
        FN_DIV = 2'd3
    } t_alu_fn;

    typedef struct packed {
        logic    start;
        t_alu_fn fn;
    } t_alu_ctl;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RDA,
        S_RDB,
        S_RDC,
        S_CAP,
        S_DEC,
        S_ALU,
        S_WB,
        S_OUT
    } t_state;

endpackage

// ===== hw/rtl/amu_if.sv =====
interface amu_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [amu_pkg::OP_W-1:0]            operation;
    logic [amu_pkg::FORM_W-1:0]          form;
    logic [amu_pkg::ADDR_W-1:0]          addr_a;
    logic [amu_pkg::ADDR_W-1:0]          addr_b;
    logic [amu_pkg::ADDR_W-1:0]          addr_c;
    logic signed [amu_pkg::VALUE_W-1:0]  value;
    logic                                show_acc;

    modport source (
        output valid, operation, form, addr_a, addr_b, addr_c, value, show_acc,
        input  ready
    );
    modport sink (
        input  valid, operation, form, addr_a, addr_b, addr_c, value, show_acc,
        output ready
    );
endinterface

interface amu_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [amu_pkg::VALUE_W-1:0]  read_data;
    logic signed [amu_pkg::VALUE_W-1:0]  acc_value;
    logic [amu_pkg::STATUS_W-1:0]        status;

    modport source (
        output valid, read_data, acc_value, status,
        input  ready
    );
    modport sink (
        input  valid, read_data, acc_value, status,
        output ready
    );
endinterface

// ===== hw/rtl/amu_store.sv =====
module amu_store #(
    parameter int ENTRIES    = amu_pkg::ENTRIES_DEF,
    parameter int DATA_WIDTH = amu_pkg::DATA_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_we,
    input  logic [$clog2(ENTRIES)-1:0] i_waddr,
    input  logic [DATA_WIDTH-1:0]      i_wdata,
    input  logic [$clog2(ENTRIES)-1:0] i_raddr,
    output logic [DATA_WIDTH-1:0]      o_rdata,
    output logic                       o_rvld,
    output logic                       o_clr_busy
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    logic [DATA_WIDTH-1:0] mem_data [ENTRIES];
    logic                  mem_vld  [ENTRIES];

    logic             r_clr_busy;
    logic [IDX_W-1:0] r_clr_idx;

    // valid marks swept to zero after reset, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == LAST_IDX) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem_vld[r_clr_idx] <= 1'b0;
        end else if (i_we) begin
            mem_vld[i_waddr] <= 1'b1;
        end
        o_rvld <= mem_vld[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem_data[i_waddr] <= i_wdata;
        end
        o_rdata <= mem_data[i_raddr];
    end

    assign o_clr_busy = r_clr_busy;

endmodule

// ===== hw/rtl/amu_alu.sv =====
module amu_alu #(
    parameter int DATA_WIDTH = amu_pkg::DATA_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  amu_pkg::t_alu_ctl         i_ctl,
    input  logic [DATA_WIDTH-1:0]     i_x,
    input  logic [DATA_WIDTH-1:0]     i_y,
    output logic [DATA_WIDTH-1:0]     o_result,
    output logic                      o_done
);

    localparam int DW    = DATA_WIDTH;
    localparam int CNT_W = $clog2(DW + 3);
    // div step plan: abs(x), abs(y), DW restoring steps, sign fixup at zero
    localparam logic [CNT_W-1:0] C_DIV_NX = CNT_W'(DW + 2);
    localparam logic [CNT_W-1:0] C_DIV_NY = CNT_W'(DW + 1);
    localparam logic [CNT_W-1:0] C_MUL    = CNT_W'(DW - 1);

    amu_pkg::t_alu_fn r_fn;
    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_p;     // sum, product or remainder
    logic [DW-1:0]    r_q;     // multiplier or quotient
    logic [DW-1:0]    r_d;     // addend, multiplicand or divisor
    logic             r_neg;

    logic [DW:0]   opl;
    logic [DW:0]   opr;
    logic          inv;
    logic [DW+1:0] sum;

    // the one shared adder
    always_comb begin
        opl = {1'b0, r_p};
        opr = {1'b0, r_d};
        inv = 1'b0;
        case (r_fn)
            amu_pkg::FN_SUB: begin
                inv = 1'b1;
            end
            amu_pkg::FN_DIV: begin
                inv = 1'b1;
                if (r_cnt == C_DIV_NX || r_cnt == '0) begin
                    opl = '0;
                    opr = {1'b0, r_q};
                end else if (r_cnt == C_DIV_NY) begin
                    opl = '0;
                end else begin
                    opl = {r_p, r_q[DW-1]};
                end
            end
            default: begin
            end
        endcase
        sum = {1'b0, opl} + {1'b0, opr ^ {(DW+1){inv}}} + (DW+2)'(inv);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_fn   <= amu_pkg::FN_ADD;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_fn   <= i_ctl.fn;
                case (i_ctl.fn)
                    amu_pkg::FN_MUL: r_cnt <= C_MUL;
                    amu_pkg::FN_DIV: r_cnt <= C_DIV_NX;
                    default:         r_cnt <= '0;
                endcase
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_p   <= (i_ctl.fn == amu_pkg::FN_ADD || i_ctl.fn == amu_pkg::FN_SUB) ? i_x : '0;
            r_q   <= i_x;
            r_d   <= i_y;
            r_neg <= i_x[DW-1] ^ i_y[DW-1];
        end else if (r_busy) begin
            case (r_fn)
                amu_pkg::FN_MUL: begin
                    if (r_q[0]) begin
                        r_p <= sum[DW-1:0];
                    end
                    r_d <= r_d << 1;
                    r_q <= r_q >> 1;
                end
                amu_pkg::FN_DIV: begin
                    if (r_cnt == C_DIV_NX) begin
                        if (r_q[DW-1]) begin
                            r_q <= sum[DW-1:0];
                        end
                    end else if (r_cnt == C_DIV_NY) begin
                        if (r_d[DW-1]) begin
                            r_d <= sum[DW-1:0];
                        end
                    end else if (r_cnt == '0) begin
                        if (r_neg) begin
                            r_q <= sum[DW-1:0];
                        end
                    end else begin
                        // carry out set: partial remainder not below divisor
                        r_p <= sum[DW+1] ? sum[DW-1:0] : opl[DW-1:0];
                        r_q <= {r_q[DW-2:0], sum[DW+1]};
                    end
                end
                default: begin
                    r_p <= sum[DW-1:0];
                end
            endcase
        end
    end

    assign o_result = (r_fn == amu_pkg::FN_DIV) ? r_q : r_p;
    assign o_done   = r_done;

endmodule

// ===== hw/rtl/accumulator_machine_execute_unit.sv =====
// Sequence, accept to result valid: RDA, RDB, RDC, CAP, DEC; then set, load, store, show,
// no-op codes and arithmetic that stops on a status go to OUT; move goes through WB; add,
// sub, inc, dec, mul and div wait in ALU until the shared ALU is done, then go through WB.
// A new word is taken only after the last result has been taken; the store's single read
// port (three operand reads) and the bit-per-cycle shared ALU set the pace.
// Reset (i_rst_n low, synchronous): accumulator zero, then a sweep clears the valid
// marks of all ENTRIES entries, during which no command word is taken.
module accumulator_machine_execute_unit #(
    parameter int ENTRIES    = amu_pkg::ENTRIES_DEF,
    parameter int DATA_WIDTH = amu_pkg::DATA_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    amu_cmd_if.sink        i_cmd,
    amu_res_if.source      o_res
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int ADDR_N = 2 ** amu_pkg::ADDR_W;
    localparam int DW     = DATA_WIDTH;

    // ------------------------------------------------------------------
    // address reduction: constant table, addr modulo ENTRIES
    // ------------------------------------------------------------------
    logic [IDX_W-1:0] mod_tbl [ADDR_N];

    for (genvar g = 0; g < ADDR_N; g++) begin : g_mod
        localparam int MODV = g % ENTRIES;
        assign mod_tbl[g] = IDX_W'(MODV);
    end

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    amu_pkg::t_state  r_state, n_state;
    amu_pkg::t_op     r_op;
    logic [amu_pkg::FORM_W-1:0] r_form;
    logic [IDX_W-1:0] r_ia, r_ib, r_ic;
    logic [DW-1:0]    r_imm;
    logic             r_show_acc;

    logic [DW-1:0]    r_opa, r_opb;     // store[a], store[b]
    logic             r_va, r_vb, r_vc; // their valid marks, and c's
    logic [DW-1:0]    r_acc, n_acc;
    logic [DW-1:0]    r_rd, n_rd;
    amu_pkg::t_status r_status, n_status;

    logic             accept;

    // store port
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [DW-1:0]    mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    logic [DW-1:0]    mem_rdata;
    logic             mem_rvld;
    logic             clr_busy;

    // shared ALU
    amu_pkg::t_alu_ctl alu_ctl;
    logic [DW-1:0]     alu_x, alu_y, alu_res;
    logic              alu_done;

    // operand decode, valid in S_DEC
    logic          is_arith;
    logic          is_incdec;
    logic          miss;
    logic [DW-1:0] x_sel, y_sel, cur;

    assign accept      = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == amu_pkg::S_IDLE);

    amu_store #(
        .ENTRIES    (ENTRIES),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (mem_we),
        .i_waddr    (mem_waddr),
        .i_wdata    (mem_wdata),
        .i_raddr    (mem_raddr),
        .o_rdata    (mem_rdata),
        .o_rvld     (mem_rvld),
        .o_clr_busy (clr_busy)
    );

    amu_alu #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (alu_ctl),
        .i_x      (alu_x),
        .i_y      (alu_y),
        .o_result (alu_res),
        .o_done   (alu_done)
    );

    // one operand read per state; the store registers its read data
    always_comb begin
        case (r_state)
            amu_pkg::S_RDB: mem_raddr = r_ib;
            amu_pkg::S_RDC: mem_raddr = r_ic;
            default:        mem_raddr = r_ia;
        endcase
    end

    always_comb begin
        is_arith  = (r_op == amu_pkg::OP_ADD) || (r_op == amu_pkg::OP_SUB) ||
                    (r_op == amu_pkg::OP_MUL) || (r_op == amu_pkg::OP_DIV);
        is_incdec = (r_op == amu_pkg::OP_INC) || (r_op == amu_pkg::OP_DEC);
        // form 3 also needs the destination marked
        miss      = !r_va || (r_form[1] && !r_vb) || (r_form == 2'd3 && !r_vc);
        x_sel     = (r_form == 2'd1) ? r_acc : r_opa;
        y_sel     = (r_form == 2'd1) ? r_opa : r_opb;
        cur       = r_va ? r_opa : '0;   // inc, dec, move read unwritten as zero
        alu_x     = is_incdec ? cur : x_sel;
        alu_y     = is_incdec ? DW'(1) : y_sel;
    end

    // ------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            amu_pkg::S_CLEAR: begin
                if (!clr_busy) begin
                    n_state = amu_pkg::S_IDLE;
                end
            end
            amu_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = amu_pkg::S_RDA;
                end
            end
            amu_pkg::S_RDA: n_state = amu_pkg::S_RDB;
            amu_pkg::S_RDB: n_state = amu_pkg::S_RDC;
            amu_pkg::S_RDC: n_state = amu_pkg::S_CAP;
            amu_pkg::S_CAP: n_state = amu_pkg::S_DEC;
            amu_pkg::S_DEC: begin
                unique case (r_op) inside
                    amu_pkg::OP_ADD, amu_pkg::OP_SUB, amu_pkg::OP_MUL,
                    amu_pkg::OP_DIV: begin
                        if (r_form == 2'd0 || miss) begin
                            n_state = amu_pkg::S_OUT;
                        end else if (r_op == amu_pkg::OP_DIV && y_sel == '0) begin
                            n_state = amu_pkg::S_OUT;
                        end else begin
                            n_state = amu_pkg::S_ALU;
                        end
                    end
                    amu_pkg::OP_INC, amu_pkg::OP_DEC: n_state = amu_pkg::S_ALU;
                    amu_pkg::OP_MOVE:                 n_state = amu_pkg::S_WB;
                    default:                          n_state = amu_pkg::S_OUT;
                endcase
            end
            amu_pkg::S_ALU: begin
                if (alu_done) begin
                    n_state = amu_pkg::S_WB;
                end
            end
            amu_pkg::S_WB: n_state = amu_pkg::S_OUT;
            amu_pkg::S_OUT: begin
                if (o_res.ready) begin
                    n_state = amu_pkg::S_IDLE;
                end
            end
            default: n_state = amu_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer: datapath controls
    // ------------------------------------------------------------------
    always_comb begin
        n_acc       = r_acc;
        n_rd        = r_rd;
        n_status    = r_status;
        mem_we      = 1'b0;
        mem_waddr   = r_ia;
        mem_wdata   = alu_res;
        alu_ctl     = '{start: 1'b0, fn: amu_pkg::FN_ADD};
        unique case (r_state)
            amu_pkg::S_IDLE: begin
                if (accept) begin
                    n_rd     = '0;
                    n_status = amu_pkg::ST_OK;
                end
            end
            amu_pkg::S_DEC: begin
                unique case (r_op) inside
                    amu_pkg::OP_SET: begin
                        mem_we    = 1'b1;
                        mem_wdata = r_imm;
                    end
                    amu_pkg::OP_ADD, amu_pkg::OP_SUB, amu_pkg::OP_MUL,
                    amu_pkg::OP_DIV: begin
                        if (r_form == 2'd0) begin
                            n_status = amu_pkg::ST_OK;
                        end else if (miss) begin
                            n_status = amu_pkg::ST_MISS;
                        end else if (r_op == amu_pkg::OP_DIV && y_sel == '0) begin
                            n_status = amu_pkg::ST_DIV0;
                        end else begin
                            alu_ctl.start = 1'b1;
                            case (r_op)
                                amu_pkg::OP_SUB: alu_ctl.fn = amu_pkg::FN_SUB;
                                amu_pkg::OP_MUL: alu_ctl.fn = amu_pkg::FN_MUL;
                                amu_pkg::OP_DIV: alu_ctl.fn = amu_pkg::FN_DIV;
                                default:         alu_ctl.fn = amu_pkg::FN_ADD;
                            endcase
                        end
                    end
                    amu_pkg::OP_INC, amu_pkg::OP_DEC: begin
                        alu_ctl.start = 1'b1;
                        alu_ctl.fn    = (r_op == amu_pkg::OP_DEC) ? amu_pkg::FN_SUB
                                                                  : amu_pkg::FN_ADD;
                    end
                    amu_pkg::OP_MOVE: begin
                        // b first, so a == b ends as zero after write-back
                        mem_we    = 1'b1;
                        mem_waddr = r_ib;
                        mem_wdata = cur;
                    end
                    amu_pkg::OP_LOAD: begin
                        if (r_va) begin
                            n_acc = r_opa;
                        end else begin
                            n_status = amu_pkg::ST_MISS;
                        end
                    end
                    amu_pkg::OP_STORE: begin
                        mem_we    = 1'b1;
                        mem_wdata = r_acc;
                    end
                    amu_pkg::OP_SHOW: begin
                        if (r_show_acc) begin
                            n_rd = r_acc;
                        end else if (r_va) begin
                            n_rd = r_opa;
                        end else begin
                            n_status = amu_pkg::ST_MISS;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            amu_pkg::S_WB: begin
                if (r_op == amu_pkg::OP_MOVE) begin
                    mem_we    = 1'b1;
                    mem_wdata = '0;
                end else begin
                    n_acc = alu_res;
                    if (is_incdec) begin
                        mem_we = 1'b1;
                    end else if (is_arith && r_form == 2'd3) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_ic;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= amu_pkg::S_CLEAR;
            r_acc    <= '0;
            r_status <= amu_pkg::ST_OK;
        end else begin
            r_state  <= n_state;
            r_acc    <= n_acc;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= n_rd;
        if (accept) begin
            r_op       <= amu_pkg::t_op'(i_cmd.operation);
            r_form     <= i_cmd.form;
            r_ia       <= mod_tbl[i_cmd.addr_a];
            r_ib       <= mod_tbl[i_cmd.addr_b];
            r_ic       <= mod_tbl[i_cmd.addr_c];
            r_imm      <= DW'(i_cmd.value);   // sign-extends or truncates
            r_show_acc <= i_cmd.show_acc;
        end
        if (r_state == amu_pkg::S_RDB) begin
            r_opa <= mem_rdata;
            r_va  <= mem_rvld;
        end
        if (r_state == amu_pkg::S_RDC) begin
            r_opb <= mem_rdata;
            r_vb  <= mem_rvld;
        end
        if (r_state == amu_pkg::S_CAP) begin
            r_vc <= mem_rvld;
        end
    end

    // result word straight from registers; values zero-extend past DATA_WIDTH
    assign o_res.valid     = (r_state == amu_pkg::S_OUT);
    assign o_res.read_data = amu_pkg::VALUE_W'(r_rd);
    assign o_res.acc_value = amu_pkg::VALUE_W'(r_acc);
    assign o_res.status    = r_status;

`ifndef SYNTHESIS
    // a new command never completes in the very next cycle
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_res.valid)
        else $error("result valid one cycle after accept");

    // the ALU only finishes while the sequencer waits for it
    a_alu_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_done |-> (r_state == amu_pkg::S_ALU))
        else $error("ALU done outside wait state");

    // no store write may race the valid-mark sweep
    a_no_write_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> !mem_we)
        else $error("store written during clearing sweep");

    // divide-by-zero status only comes from a div command
    a_div0_only_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && r_status == amu_pkg::ST_DIV0) |-> (r_op == amu_pkg::OP_DIV))
        else $error("div-by-zero status on non-div command");
`endif

endmodule
